// ===== hdl/rfb_pkg.sv =====
// Shared types and constants of the request frame builder.
package rfb_pkg;

	// Field widths
	localparam int unsigned BYTE_W  = 8;
	localparam int unsigned WORD_W  = 16;
	localparam int unsigned LEN_W   = 13;
	localparam int unsigned FLEN_W  = 14;
	localparam int unsigned S_DATA_W = 40;
	localparam int unsigned M_DATA_W = 24;

	// Largest burst of output bytes caused by one input beat
	localparam int unsigned BURST_MAX = 9;
	localparam int unsigned CNT_W     = 4;

	// Frame constants
	localparam logic [WORD_W-1:0] HEADER_EXTRA  = 16'd9;
	localparam logic [WORD_W-1:0] SOP_LEN_BYTES = 16'd4;
	localparam logic [BYTE_W-1:0] STUFF_FILL    = 8'h00;

	// Input kinds carried on tuser
	localparam logic CMD_START   = 1'b0;
	localparam logic CMD_PAYLOAD = 1'b1;

	// Register indexes
	localparam logic REG_START_WORD   = 1'b0;
	localparam logic REG_STUFF_MARKER = 1'b1;

	typedef struct packed {
		logic [WORD_W-1:0] start_word;
		logic [BYTE_W-1:0] stuff_marker;
	} cfg_t;

	typedef struct packed {
		logic [BURST_MAX-1:0][BYTE_W-1:0] bytes;
		logic [CNT_W-1:0]                 count;
		logic                             eof;
		logic [FLEN_W-1:0]                flen;
	} burst_t;

endpackage

// ===== hdl/request_frame_builder_stuffing_xor.sv =====
// An accepted beat passes the input register, then the burst shift register, to the output.
// Throughput: one input beat per cycle while output bursts keep pace; a start beat
// yields 8 or 9 output beats, a framed payload beat 1 to 3; one byte per cycle if m_tready.
// The output shift register sets the pace: the next burst loads as its last byte leaves.
// Reset (arst_n low, asynchronous) clears registers, frame state and the pending burst.
module request_frame_builder_stuffing_xor
	import rfb_pkg::*;
#(
	parameter int unsigned MAX_PAYLOAD = 4096
)
(
	input  logic                clk,
	input  logic                arst_n,
	// APB configuration
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [2:0]          paddr,
	input  logic [31:0]         pwdata,
	output logic [31:0]         prdata,
	output logic                pready,
	// Input stream
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic                s_tuser,   // cmd
	input  logic [S_DATA_W-1:0] s_tdata,   // command_code[15:0], payload_length[28:16],
	                                       // payload_byte[36:29], zero fill
	// Output stream
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic                m_tlast,   // end_of_frame
	output logic [M_DATA_W-1:0] m_tdata    // out_byte[7:0], frame_length[21:8], zero fill
);

	cfg_t   cfg;
	burst_t burst;
	logic   burst_load;
	logic   burst_free;

	rfb_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	rfb_core #(
		.MAX_PAYLOAD (MAX_PAYLOAD)
	) u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tuser    (s_tuser),
		.s_tdata    (s_tdata),
		.cfg        (cfg),
		.burst_free (burst_free),
		.burst_load (burst_load),
		.burst      (burst)
	);

	rfb_serial u_serial (
		.clk        (clk),
		.arst_n     (arst_n),
		.burst_load (burst_load),
		.burst      (burst),
		.burst_free (burst_free),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tlast    (m_tlast),
		.m_tdata    (m_tdata)
	);

endmodule

// ===== hdl/rfb_cfg.sv =====
// APB register file holding the start word and the stuff marker.
module rfb_cfg
	import rfb_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	output cfg_t        cfg
);

	logic [WORD_W-1:0] start_word_q;
	logic [BYTE_W-1:0] stuff_marker_q;
	logic              wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite & pready;

	// Register writes, word addressed by paddr[2]
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_word_q   <= '0;
			stuff_marker_q <= '0;
		end else if (wr_en) begin
			case (paddr[2])
				REG_START_WORD:   start_word_q   <= pwdata[WORD_W-1:0];
				REG_STUFF_MARKER: stuff_marker_q <= pwdata[BYTE_W-1:0];
				default:          ;
			endcase
		end
	end

	// Read back
	always_comb begin
		case (paddr[2])
			REG_START_WORD:   prdata = {16'h0000, start_word_q};
			REG_STUFF_MARKER: prdata = {24'h000000, stuff_marker_q};
			default:          prdata = '0;
		endcase
	end

	assign cfg.start_word   = start_word_q;
	assign cfg.stuff_marker = stuff_marker_q;

endmodule

// ===== hdl/rfb_core.sv =====
// Input register, frame state and burst builder of the request framer.
module rfb_core
	import rfb_pkg::*;
#(
	parameter int unsigned MAX_PAYLOAD = 4096
)
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic                s_tuser,
	input  logic [S_DATA_W-1:0] s_tdata,
	input  cfg_t                cfg,
	input  logic                burst_free,
	output logic                burst_load,
	output burst_t              burst
);

	// Input register
	logic              v_s1;
	logic              cmd_s1;
	logic [WORD_W-1:0] code_s1;
	logic [LEN_W-1:0]  plen_s1;
	logic [BYTE_W-1:0] byte_s1;

	// Frame state
	logic              in_frame_q;
	logic [LEN_W-1:0]  remaining_q;
	logic [BYTE_W-1:0] xor_q;
	logic [LEN_W-1:0]  stuffed_q;
	logic [LEN_W-1:0]  base_q;

	logic              advance;
	logic [LEN_W-1:0]  plen_sat;
	logic [WORD_W-1:0] lenfield;
	logic [BYTE_W-1:0] hdr_xor;
	logic              pay_ok;
	logic              stuff;
	logic [LEN_W-1:0]  rem_next;
	logic              fin;
	logic [BYTE_W-1:0] pay_xor;
	logic [LEN_W-1:0]  stuffed_next;
	logic [FLEN_W-1:0] pay_total;

	assign advance  = v_s1 & burst_free;
	assign s_tready = ~v_s1 | burst_free;

	// Input register takes a beat whenever the previous one moves on
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (s_tready) begin
			v_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			cmd_s1  <= s_tuser;
			code_s1 <= s_tdata[15:0];
			plen_s1 <= s_tdata[28:16];
			byte_s1 <= s_tdata[36:29];
		end
	end

	// Start beat: saturated length, length field and header checksum
	assign plen_sat = ({19'd0, plen_s1} > MAX_PAYLOAD) ? LEN_W'(MAX_PAYLOAD) : plen_s1;
	assign lenfield = {3'd0, plen_sat} + HEADER_EXTRA - SOP_LEN_BYTES;
	assign hdr_xor  = lenfield[15:8] ^ code_s1[7:0] ^ code_s1[15:8];

	// Payload beat: stuffing, checksum and end of frame
	assign pay_ok       = in_frame_q & (remaining_q != '0);
	assign stuff        = (byte_s1 == cfg.stuff_marker);
	assign rem_next     = remaining_q - LEN_W'(1);
	assign fin          = (rem_next == '0);
	assign pay_xor      = xor_q ^ byte_s1;
	assign stuffed_next = stuffed_q + LEN_W'(stuff);
	assign pay_total    = FLEN_W'(base_q) + FLEN_W'(HEADER_EXTRA) + FLEN_W'(stuffed_next);

	// Burst contents for the beat in the input register
	always_comb begin
		burst = '0;
		if (cmd_s1 == CMD_START) begin
			burst.bytes[0] = cfg.start_word[7:0];
			burst.bytes[1] = cfg.start_word[15:8];
			burst.bytes[2] = lenfield[7:0];
			burst.bytes[3] = lenfield[15:8];
			burst.bytes[4] = 8'h00;
			burst.bytes[5] = 8'h00;
			burst.bytes[6] = code_s1[7:0];
			burst.bytes[7] = code_s1[15:8];
			burst.bytes[8] = hdr_xor;
			if (plen_sat == '0) begin
				burst.count = CNT_W'(9);
				burst.eof   = 1'b1;
				burst.flen  = FLEN_W'(HEADER_EXTRA);
			end else begin
				burst.count = CNT_W'(8);
			end
		end else if (pay_ok) begin
			burst.bytes[0] = byte_s1;
			burst.bytes[1] = stuff ? STUFF_FILL : pay_xor;
			burst.bytes[2] = pay_xor;
			burst.count    = CNT_W'(1) + CNT_W'(stuff) + CNT_W'(fin);
			burst.eof      = fin;
			burst.flen     = pay_total;
		end
	end

	assign burst_load = advance & (burst.count != '0);

	// Frame state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_frame_q  <= 1'b0;
			remaining_q <= '0;
			xor_q       <= '0;
			stuffed_q   <= '0;
			base_q      <= '0;
		end else if (advance) begin
			if (cmd_s1 == CMD_START) begin
				base_q      <= plen_sat;
				remaining_q <= plen_sat;
				stuffed_q   <= '0;
				xor_q       <= hdr_xor;
				in_frame_q  <= (plen_sat != '0);
			end else if (pay_ok) begin
				remaining_q <= rem_next;
				stuffed_q   <= stuffed_next;
				xor_q       <= pay_xor;
				if (fin) begin
					in_frame_q <= 1'b0;
				end
			end
		end
	end

endmodule

// ===== hdl/rfb_serial.sv =====
// Result register that shifts one burst out as single byte beats.
module rfb_serial
	import rfb_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                burst_load,
	input  burst_t              burst,
	output logic                burst_free,
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic                m_tlast,
	output logic [M_DATA_W-1:0] m_tdata
);

	logic [BURST_MAX-1:0][BYTE_W-1:0] bytes_q;
	logic [CNT_W-1:0]                 cnt_q;
	logic                             eof_q;
	logic [FLEN_W-1:0]                flen_q;
	logic                             take;

	assign m_tvalid   = (cnt_q != '0);
	assign take       = m_tvalid & m_tready;
	assign burst_free = (cnt_q == '0) | ((cnt_q == CNT_W'(1)) & m_tready);
	assign m_tlast    = eof_q & (cnt_q == CNT_W'(1));
	assign m_tdata    = {2'b00, (m_tlast ? flen_q : FLEN_W'(0)), bytes_q[0]};

	// Byte count of the burst still to go
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (burst_load) begin
			cnt_q <= burst.count;
		end else if (take) begin
			cnt_q <= cnt_q - CNT_W'(1);
		end
	end

	// Burst bytes, shifted down one place per beat
	always_ff @(posedge clk) begin
		if (burst_load) begin
			bytes_q <= burst.bytes;
			eof_q   <= burst.eof;
			flen_q  <= burst.flen;
		end else if (take) begin
			for (int i = 0; i < BURST_MAX - 1; i++) begin
				bytes_q[i] <= bytes_q[i+1];
			end
		end
	end

endmodule

// ===== hdl/rfb_checker.sv =====
// Port-level checks of the request frame builder, bound to its top level.
module rfb_checker
	import rfb_pkg::*;
(
	input logic                clk,
	input logic                arst_n,
	input logic                psel,
	input logic                pready,
	input logic                s_tready,
	input logic                m_tvalid,
	input logic                m_tready,
	input logic                m_tlast,
	input logic [M_DATA_W-1:0] m_tdata
);

	// A stalled output beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("output beat changed while stalled");

	// Frame length shows only on the checksum beat
	a_flen_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tlast |-> m_tdata[21:8] == 14'd0)
		else $error("frame length on a non-final beat");

	// A finished frame is at least header plus checksum long
	a_flen_min: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tlast |-> m_tdata[21:8] >= 14'd9)
		else $error("frame length below header size");

	// Input is held off only while output bytes are pending
	a_in_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> m_tvalid)
		else $error("input stalled with no output pending");

	// Configuration port never stalls
	a_pready: assert property (@(posedge clk) disable iff (!arst_n)
		psel |-> pready)
		else $error("pready low");

endmodule

bind request_frame_builder_stuffing_xor rfb_checker u_rfb_checker (.*);

// ===== bench/tb_request_frame_builder_stuffing_xor.sv =====
// Self-checking testbench for the byte-stuffed request framer with XOR checksum.
`timescale 1ns / 100ps

module tb_request_frame_builder_stuffing_xor;
	import rfb_pkg::*;

	localparam int unsigned MAX_PAYLOAD = 4096;
	localparam int unsigned HOLD_CYCLES = 400;
	localparam int unsigned TAIL_CYCLES = 12;

	logic                clk;
	logic                arst_n;
	logic                psel;
	logic                penable;
	logic                pwrite;
	logic [2:0]          paddr;
	logic [31:0]         pwdata;
	logic [31:0]         prdata;
	logic                pready;
	logic                s_tvalid;
	logic                s_tready;
	logic                s_tuser;   // cmd
	logic [S_DATA_W-1:0] s_tdata;   // command_code, payload_length, payload_byte, zero fill
	logic                m_tvalid;
	logic                m_tready;
	logic                m_tlast;   // end_of_frame
	logic [M_DATA_W-1:0] m_tdata;   // out_byte, frame_length, zero fill

	// Set by the main sequence: gap control for the sender, a hold request for the receiver
	bit tx_no_gaps;
	bit hold_request;

	// One outgoing frame byte as the block should send it
	typedef struct {
		logic [BYTE_W-1:0] value;
		logic              eof;
		logic [FLEN_W-1:0] flen;
	} frame_byte_t;

	// Frame predictor: tracks the open frame and queues the bytes it must produce
	class frame_checker;
		logic [WORD_W-1:0] start_word;
		logic [BYTE_W-1:0] stuff_marker;
		bit                open;
		int                remaining;
		int                base_len;
		int                stuffed;
		logic [BYTE_W-1:0] chk;
		frame_byte_t       expected_bytes[$];
		int                errors;
		int                n_inputs;
		int                n_frames;
		int                n_stuffed;
		int                n_beats;

		function void set_reg(logic idx, logic [31:0] value);
			if (idx == REG_START_WORD)
				start_word = value[WORD_W-1:0];
			else
				stuff_marker = value[BYTE_W-1:0];
		endfunction

		function void push_byte(logic [BYTE_W-1:0] value, logic eof, logic [FLEN_W-1:0] flen);
			frame_byte_t fb;
			fb.value = value;
			fb.eof   = eof;
			fb.flen  = flen;
			expected_bytes.push_back(fb);
		endfunction

		// byte that also enters the checksum
		function void push_summed(logic [BYTE_W-1:0] value);
			chk = chk ^ value;
			push_byte(value, 1'b0, '0);
		endfunction

		function void close_frame();
			int total;
			total = base_len + int'(HEADER_EXTRA) + stuffed;
			push_byte(chk, 1'b1, total[FLEN_W-1:0]);
			open      = 1'b0;
			remaining = 0;
			n_frames++;
		endfunction

		// Called for every accepted input beat
		function void note_beat(logic cmd, logic [WORD_W-1:0] code, logic [LEN_W-1:0] plen,
		                        logic [BYTE_W-1:0] pbyte);
			int               plen_sat;
			logic [WORD_W-1:0] len_field;
			n_inputs++;
			if (cmd == CMD_START) begin
				plen_sat  = (plen > MAX_PAYLOAD) ? int'(MAX_PAYLOAD) : int'(plen);
				len_field = WORD_W'(plen_sat + HEADER_EXTRA - SOP_LEN_BYTES);
				base_len  = plen_sat;
				remaining = plen_sat;
				stuffed   = 0;
				chk       = '0;
				open      = 1'b1;
				push_byte(start_word[7:0], 1'b0, '0);
				push_byte(start_word[15:8], 1'b0, '0);
				push_byte(len_field[7:0], 1'b0, '0);
				push_summed(len_field[15:8]);
				push_summed(8'h00);
				push_summed(8'h00);
				push_summed(code[7:0]);
				push_summed(code[15:8]);
				if (remaining == 0)
					close_frame();
			end else if (open && remaining != 0) begin
				push_summed(pbyte);
				if (pbyte == stuff_marker) begin
					push_summed(STUFF_FILL);
					stuffed++;
					n_stuffed++;
				end
				remaining--;
				if (remaining == 0)
					close_frame();
			end
		endfunction

		// Called for every accepted output beat
		function void check_byte(logic [BYTE_W-1:0] value, logic eof, logic [FLEN_W-1:0] flen);
			frame_byte_t exp_b;
			if (expected_bytes.size() == 0) begin
				$error("unexpected output beat: out_byte %02h end_of_frame %0b", value, eof);
				errors++;
				return;
			end
			exp_b = expected_bytes.pop_front();
			n_beats++;
			if (value !== exp_b.value) begin
				$error("out_byte: expected %02h, got %02h", exp_b.value, value);
				errors++;
			end
			if (eof !== exp_b.eof) begin
				$error("end_of_frame: expected %0b, got %0b", exp_b.eof, eof);
				errors++;
			end
			if (flen !== exp_b.flen) begin
				$error("frame_length: expected %0d, got %0d", exp_b.flen, flen);
				errors++;
			end
		endfunction
	endclass

	frame_checker sb = new;

	request_frame_builder_stuffing_xor #(
		.MAX_PAYLOAD(MAX_PAYLOAD)
	) i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tuser  (s_tuser),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tlast  (m_tlast),
		.m_tdata  (m_tdata)
	);

	// 4 ns clock
	always begin
		clk = 1'b1;
		#2;
		clk = 1'b0;
		#2;
	end

	// Idle length: mostly none or short, now and then long
	function automatic int pick_gap();
		int r;
		r = $urandom_range(99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	// Register write with read-back; starts and ends at a falling edge
	task automatic write_reg(logic idx, logic [31:0] value);
		logic [31:0] rd;
		logic [31:0] want;
		want = (idx == REG_START_WORD) ? (value & 32'h0000_FFFF) : (value & 32'h0000_00FF);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= value;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		sb.set_reg(idx, value);
		@(negedge clk);
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		rd = prdata;
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		if (rd !== want) begin
			$error("prdata: expected %08h, got %08h", want, rd);
			sb.errors++;
		end
	endtask

	// Offer one input beat and hold it until accepted
	task automatic send_beat(logic cmd, logic [WORD_W-1:0] code, logic [LEN_W-1:0] plen,
	                         logic [BYTE_W-1:0] pbyte);
		int gap;
		gap = tx_no_gaps ? 0 : pick_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= cmd;
		s_tdata  <= {3'b000, pbyte, plen, code};
		do @(posedge clk); while (!s_tready);
		sb.note_beat(cmd, code, plen, pbyte);
		@(negedge clk);
	endtask

	// Drop valid and let every predicted byte drain, plus a short tail
	task automatic wait_idle();
		s_tvalid <= 1'b0;
		while (sb.expected_bytes.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(negedge clk);
	endtask

	// Random frames: mostly well formed, some abandoned, some stray payload beats
	task automatic run_frames(int n_items);
		int                count;
		int                r;
		int                plen;
		int                n_send;
		bit                abandon;
		logic [BYTE_W-1:0] b;
		count = 0;
		while (count < n_items) begin
			tx_no_gaps = ($urandom_range(3) == 0);
			r = $urandom_range(99);
			if (r < 12)
				plen = 0;
			else if (r < 75)
				plen = $urandom_range(1, 8);
			else if (r < 94)
				plen = $urandom_range(9, 32);
			else if (r < 97)
				plen = $urandom_range(33, 80);
			else
				plen = $urandom_range(MAX_PAYLOAD + 1, 8191);
			abandon = (plen > 80) || ($urandom_range(99) < 8);
			n_send = plen;
			if (abandon && plen > 0)
				n_send = $urandom_range(0, (plen < 6) ? plen - 1 : 5);
			send_beat(CMD_START, WORD_W'($urandom), plen[LEN_W-1:0], BYTE_W'($urandom));
			count++;
			for (int k = 0; k < n_send; k++) begin
				b = ($urandom_range(3) == 0) ? sb.stuff_marker : BYTE_W'($urandom);
				send_beat(CMD_PAYLOAD, WORD_W'($urandom), LEN_W'($urandom), b);
				count++;
			end
			// stray payload after a closed frame must be dropped
			if (n_send == plen && $urandom_range(99) < 12)
				send_beat(CMD_PAYLOAD, WORD_W'($urandom), LEN_W'($urandom),
				          BYTE_W'($urandom));
		end
		tx_no_gaps = 1'b0;
	endtask

	// Receiver: sample at the rising edge, pick tready at the falling edge
	initial begin
		int gap_left;
		int hold_left;
		int mode_left;
		bit always_ready;
		gap_left     = 0;
		hold_left    = 0;
		mode_left    = 0;
		always_ready = 1'b0;
		m_tready     = 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && m_tvalid && m_tready)
				sb.check_byte(m_tdata[7:0], m_tlast, m_tdata[21:8]);
			@(negedge clk);
			if (mode_left == 0) begin
				always_ready = ($urandom_range(3) == 0);
				mode_left    = $urandom_range(20, 120);
			end else begin
				mode_left--;
			end
			if (hold_request) begin
				hold_request = 1'b0;
				hold_left    = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else if (gap_left > 0) begin
				gap_left--;
				m_tready <= 1'b0;
			end else if (!always_ready && $urandom_range(3) == 0) begin
				gap_left = pick_gap();
				m_tready <= (gap_left == 0);
				if (gap_left > 0)
					gap_left--;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// Run limit
	initial begin
		#4000000;
		$display("tb_request_frame_builder_stuffing_xor failed");
		$finish;
	end

	// Main sequence
	initial begin
		logic [WORD_W-1:0] sw_list[5];
		logic [BYTE_W-1:0] sm_list[5];
		arst_n     = 1'b0;
		psel       = 1'b0;
		penable    = 1'b0;
		pwrite     = 1'b0;
		paddr      = '0;
		pwdata     = '0;
		s_tvalid   = 1'b0;
		s_tuser    = CMD_START;
		s_tdata    = '0;
		tx_no_gaps = 1'b0;
		hold_request = 1'b0;
		sw_list = '{16'h0000, 16'hA55A, 16'h0000, 16'h0000, 16'hFFFF};
		sm_list = '{8'h00, 8'h7E, 8'h00, 8'h00, 8'h80};
		sw_list[2] = WORD_W'($urandom);
		sm_list[2] = BYTE_W'($urandom);
		sw_list[3] = WORD_W'($urandom);
		sm_list[3] = BYTE_W'($urandom);

		repeat (9) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed part with all-ones settings
		write_reg(REG_START_WORD, 32'h0000_FFFF);
		write_reg(REG_STUFF_MARKER, 32'h0000_00FF);
		// empty payload: header and checksum at once
		send_beat(CMD_START, 16'hFFFF, 13'd0, 8'h00);
		// short frame with a stuffed byte and both byte extremes
		send_beat(CMD_START, 16'h0000, 13'd4, 8'hFF);
		send_beat(CMD_PAYLOAD, 16'h0000, 13'd0, 8'hFF);
		send_beat(CMD_PAYLOAD, 16'hFFFF, 13'h1FFF, 8'h00);
		send_beat(CMD_PAYLOAD, 16'h0000, 13'd0, 8'h55);
		send_beat(CMD_PAYLOAD, 16'h0000, 13'd0, 8'hAA);
		// payload outside a frame is dropped
		send_beat(CMD_PAYLOAD, 16'h0000, 13'd0, 8'h12);
		// oversized length saturates, then a start abandons the frame
		send_beat(CMD_START, 16'h1234, 13'h1FFF, 8'h00);
		send_beat(CMD_PAYLOAD, 16'h0000, 13'd0, 8'hFF);
		send_beat(CMD_START, 16'hABCD, 13'd2, 8'h00);
		send_beat(CMD_PAYLOAD, 16'h0000, 13'd0, 8'h7F);
		send_beat(CMD_PAYLOAD, 16'h0000, 13'd0, 8'h80);
		// length exactly at the cap, abandoned after one byte
		send_beat(CMD_START, 16'h5A5A, 13'd4096, 8'h00);
		send_beat(CMD_PAYLOAD, 16'h0000, 13'd0, 8'h01);
		send_beat(CMD_START, 16'h8001, 13'd1, 8'h00);
		send_beat(CMD_PAYLOAD, 16'h0000, 13'd0, 8'hFF);
		wait_idle();

		// Random phases over several settings
		for (int ph = 0; ph < 5; ph++) begin
			write_reg(REG_START_WORD, {16'h0000, sw_list[ph]});
			write_reg(REG_STUFF_MARKER, {24'h000000, sm_list[ph]});
			if (ph == 2)
				hold_request = 1'b1;
			run_frames(60);
			wait_idle();
		end

		$display("Run covered %0d input beats, %0d closed frames, %0d stuffed bytes,",
		         sb.n_inputs, sb.n_frames, sb.n_stuffed);
		$display("%0d output beats checked over six register settings and one long hold-off.",
		         sb.n_beats);
		if (sb.errors == 0)
			$display("tb_request_frame_builder_stuffing_xor passed");
		else
			$display("tb_request_frame_builder_stuffing_xor failed");
		$finish;
	end

endmodule

// ===== filelist.f =====
hdl/rfb_pkg.sv
hdl/rfb_cfg.sv
hdl/rfb_core.sv
hdl/rfb_serial.sv
hdl/request_frame_builder_stuffing_xor.sv
hdl/rfb_checker.sv
bench/tb_request_frame_builder_stuffing_xor.sv
